/* rtl/scht_pkg.sv */
// Package: types, constants and state encoding for the sorted chain hash table
package scht_pkg;
  localparam int NUM_BUCKETS = 128;
  localparam int NUM_NODES   = 256;
  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int NW = $clog2(NUM_NODES);
  localparam int LW = NW + 1;
  localparam int KW = 31;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [LW-1:0] NIL = LW'(NUM_NODES);

  typedef struct packed {
    logic [1:0]    operation;
    logic [KW-1:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] bucket_index;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_HEAD, S_ALLOC, S_FREERD, S_CHECK, S_LOAD, S_WAIT, S_COMMIT, S_RESP
  } state_t;

  typedef struct packed {
    logic accept;      // latch request
    logic head_rd;     // read bucket head
    logic alloc;       // take node (free list read issued in S_ALLOC)
    logic free_pop;    // free head <= link read
    logic step;        // prev <= cur, cur <= link
    logic node_rd;     // read key/link of cur
    logic commit;      // perform writes
    logic resp_load;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_insert;
    logic is_remove;
    logic use_free;
    logic pool_full;
    logic cur_nil;
    logic advance;     // continue walk
    logic hit;         // key match at cur
  } sts_t;
endpackage

/* rtl/sorted_chain_hash_table_unit.sv */
// Top level of the sorted separate-chaining hash table
//  channel | direction | payload
//  in      | input     | req_t  {operation, key}
//  out     | output    | rsp_t  {status, bucket_index}
// Clear and an insert on a full pool skip the chain walk; an insert on a
// recycled node adds a free-list pop, and each chain node walked past adds a
// registered node-store read. The next transaction can be taken in the same
// cycle as the waiting result is taken. Synchronous reset empties all buckets
// and the pool at once. A waiting result blocks only the next acceptance;
// out_valid holds until taken.
module sorted_chain_hash_table_unit import scht_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);
  cmd_t cmd;
  sts_t sts;

  scht_ctrl u_ctrl (.clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd);
  scht_datapath u_dp (.clk, .rst, .req(in_data), .cmd, .sts, .rsp(out_data));
endmodule

/* rtl/scht_ram.sv */
// Generic single-port-write, one-read RAM with registered read
module scht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/scht_datapath.sv */
// Datapath: bucket and node stores, pool state, chain walk registers
module scht_datapath import scht_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t rsp
);
  req_t            r;
  logic [LW-1:0]   cur, prev, node, free_head, fresh_count;
  logic [NUM_BUCKETS-1:0] bvalid;
  logic [BW-1:0]   b;
  logic [NW-1:0]   head_q;
  logic [KW-1:0]   key_q;
  logic [LW-1:0]   link_q;
  logic            bvalid_q;
  logic            hwe, kwe, lwe;
  logic [NW-1:0]   hwdata, kwaddr, lwaddr, raddr, cidx;
  logic [LW-1:0]   lwdata;
  logic [1:0]      st;
  logic [LW-1:0]   first, nxt;
  logic [LW-1:0]   steps;
  logic            found;

  assign b = r.key[BW-1:0];
  assign cidx = cur[NW-1:0];
  assign first = bvalid_q ? {1'b0, head_q} : NIL;
  assign nxt = link_q[LW-1] ? NIL : link_q;

  assign sts.is_clear  = r.operation == OP_CLEAR;
  assign sts.is_insert = r.operation == OP_INSERT;
  assign sts.is_remove = r.operation == OP_REMOVE;
  assign sts.use_free  = !free_head[LW-1];
  assign sts.pool_full = free_head[LW-1] && fresh_count[LW-1];
  assign sts.cur_nil   = cur[LW-1] || steps[LW-1];
  assign sts.hit       = key_q == r.key;
  assign sts.advance   = (r.operation == OP_REMOVE) ? (key_q != r.key) : (r.key > key_q);

  assign found = !sts.cur_nil && sts.hit;

  always_comb begin
    raddr = cidx;
    if (cmd.alloc) raddr = free_head[NW-1:0];
  end

  scht_ram #(.WIDTH(NW), .DEPTH(NUM_BUCKETS)) u_head (
    .clk, .we(hwe), .waddr(b), .wdata(hwdata), .raddr(req.key[BW-1:0]), .rdata(head_q));
  scht_ram #(.WIDTH(KW), .DEPTH(NUM_NODES)) u_key (
    .clk, .we(kwe), .waddr(kwaddr), .wdata(r.key), .raddr(raddr), .rdata(key_q));
  scht_ram #(.WIDTH(LW), .DEPTH(NUM_NODES)) u_link (
    .clk, .we(lwe), .waddr(lwaddr), .wdata(lwdata), .raddr(raddr), .rdata(link_q));

  always_comb begin
    hwe = 1'b0; kwe = 1'b0; lwe = 1'b0;
    hwdata = node[NW-1:0]; kwaddr = node[NW-1:0];
    lwaddr = node[NW-1:0]; lwdata = cur;
    if (cmd.commit) begin
      if (sts.is_insert) begin
        kwe = 1'b1;
        lwe = 1'b1;
        hwe = prev[LW-1];
      end else begin
        // remove: unlink cur, push onto free list (link write done in resp)
        lwe = !prev[LW-1];
        lwaddr = prev[NW-1:0];
        lwdata = nxt;
        hwe = prev[LW-1] && !nxt[LW-1];
        hwdata = nxt[NW-1:0];
      end
    end else if (cmd.resp_load) begin
      if (sts.is_insert) begin
        // insert: link predecessor to the new node
        lwe = (st == ST_OK) && !prev[LW-1];
        lwaddr = prev[NW-1:0];
        lwdata = node;
      end else if (sts.is_remove && found) begin
        lwe = 1'b1;
        lwaddr = cidx;
        lwdata = free_head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) r <= req;
    bvalid_q <= bvalid[req.key[BW-1:0]];
    if (cmd.head_rd) begin
      cur <= first;
      prev <= NIL;
      steps <= '0;
    end
    if (cmd.step) begin
      prev <= cur;
      cur <= nxt;
      steps <= steps + 1'b1;
    end
    if (cmd.alloc) begin
      if (sts.use_free) node <= free_head;
      else node <= fresh_count;
    end
    if (cmd.commit && !sts.is_insert) node <= cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= '0;
      fresh_count <= '0;
      free_head <= NIL;
      rsp <= '0;
    end else begin
      if (cmd.alloc && !sts.use_free && !sts.pool_full) fresh_count <= fresh_count + 1'b1;
      if (cmd.free_pop) free_head <= nxt;
      if (cmd.commit) begin
        if (sts.is_insert) begin
          if (prev[LW-1]) bvalid[b] <= 1'b1;
        end else if (prev[LW-1] && nxt[LW-1]) begin
          bvalid[b] <= 1'b0;
        end
      end
      if (cmd.resp_load) begin
        if (sts.is_clear) begin
          bvalid <= '0;
          fresh_count <= '0;
          free_head <= NIL;
          rsp <= '0;
        end else if (sts.is_insert) begin
          rsp.status <= (st == ST_FULL) ? ST_FULL : ST_OK;
          rsp.bucket_index <= '0;
        end else if (!found) begin
          rsp.status <= ST_NOTFOUND;
          rsp.bucket_index <= '0;
        end else begin
          rsp.status <= ST_OK;
          rsp.bucket_index <= (r.operation == OP_SEARCH) ? 7'(b) : 7'd0;
          if (sts.is_remove) free_head <= cur;
        end
      end
      if (cmd.head_rd) st <= ST_OK;
      else if (cmd.alloc && sts.pool_full) st <= ST_FULL;
    end
  end
endmodule

/* rtl/scht_ctrl.sv */
// Controller: state machine sequencing one operation through the datapath
module scht_ctrl import scht_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state, state_next;
  logic   ov, ov_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      ov <= ov_next;
    end
  end

  assign out_valid = ov;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid && in_ready) state_next = S_HEAD;
      S_HEAD:   state_next = sts.is_clear ? S_RESP : (sts.is_insert ? S_ALLOC : S_LOAD);
      S_ALLOC:  state_next = sts.pool_full ? S_RESP : (sts.use_free ? S_FREERD : S_LOAD);
      S_FREERD: state_next = S_LOAD;
      S_LOAD:   state_next = S_WAIT;
      S_WAIT:   state_next = S_CHECK;
      S_CHECK: begin
        if (sts.cur_nil) state_next = sts.is_insert ? S_COMMIT : S_RESP;
        else if (sts.advance) state_next = S_WAIT;
        else state_next = (sts.is_insert || (sts.is_remove && sts.hit)) ? S_COMMIT : S_RESP;
      end
      S_COMMIT: state_next = S_RESP;
      S_RESP:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = (state == S_IDLE) && !(ov && !out_ready);
    ov_next = ov && !out_ready;
    case (state)
      S_IDLE:   cmd.accept = in_valid && in_ready;
      S_HEAD:   cmd.head_rd = 1'b1;
      S_ALLOC:  cmd.alloc = 1'b1;
      S_FREERD: cmd.free_pop = 1'b1;
      S_LOAD:   cmd.node_rd = 1'b1;
      S_WAIT:   cmd.node_rd = 1'b1;
      S_CHECK:  cmd.step = !sts.cur_nil && sts.advance;
      S_COMMIT: cmd.commit = 1'b1;
      S_RESP: begin
        cmd.resp_load = 1'b1;
        ov_next = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

/* rtl/scht_checker.sv */
// Port-level checker for the hash table unit, bound to the top level
module scht_checker import scht_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("accept while busy");
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != 2'd3) else $error("bad status");
  a_index_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bucket_index != '0 |-> out_data.status == ST_OK)
    else $error("index on failure");
endmodule

bind sorted_chain_hash_table_unit scht_checker u_chk (.clk, .rst, .in_valid, .in_ready,
  .out_valid, .out_ready, .out_data);
